// ===== hw/rtl/integer_to_radix_symbols_unit_defines.svh =====
// Assertion macros for the radix symbol converter.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef INTEGER_TO_RADIX_SYMBOLS_UNIT_DEFINES_SVH
`define INTEGER_TO_RADIX_SYMBOLS_UNIT_DEFINES_SVH

// Antecedent in one cycle implies the consequent in the next.
`define I2R_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2r: next-cycle check failed");

// Condition holds at every edge out of reset.
`define I2R_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("i2r: invariant check failed");

`endif

// ===== hw/rtl/i2r_pkg.sv =====
// Shared types and constants for the radix symbol converter.
// No dependencies.
package i2r_pkg;

	localparam int SYM_W      = 8;
	localparam int LEN_W      = 5;
	localparam int SYMS_W     = 64;
	localparam int NUM_SYMS   = 16;
	localparam int SYM_IDX_W  = 4;
	localparam int CHUNK_BITS = 8;
	localparam int CFG_IDX_W  = 2;

	localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
	localparam int               MIN_BASE  = 2;

	localparam logic [LEN_W-1:0]  BASE_LEN_RST = 5'd10;
	localparam logic [SYMS_W-1:0] SYMS_LO_RST  = 64'h3736353433323130;
	localparam logic [SYMS_W-1:0] SYMS_HI_RST  = 64'h0000000000003938;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMS_LO  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMS_HI  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SIGN,
		ST_READ,
		ST_EMIT
	} i2r_state_t;

	typedef struct packed {
		logic load;
		logic run;
	} div_ctrl_t;

	typedef struct packed {
		logic digit_valid;
		logic quot_zero;
	} div_stat_t;

endpackage

// ===== hw/rtl/integer_to_radix_symbols_unit.sv =====
// Top level of the radix symbol converter: sequencer, config and output beat.
// Depends on i2r_pkg, i2r_divider, i2r_ram and the assertion macro header.
//
// Usage: one signed value enters on the input channel (in_valid/in_stall);
// its text leaves on the output channel (out_valid/out_stall) as one beat
// per symbol, minus sign first for negative values, most significant digit
// next, last set on the final beat. An invalid symbol table (radix outside
// 2..MAX_BASE, or '+' or '-' among the symbols in use) swallows the value
// and no beat is sent. Configuration is written through cfg_we, cfg_index
// and cfg_wdata; the user must write it only while the block is idle, as
// the block itself does not enforce this. The shared divider takes the
// value in 8-bit chunks for each digit, digits land in a small RAM, then
// the sign goes out if any, the RAM read is primed, and the digits go out
// one per cycle while out_stall is low. in_stall is high from acceptance
// until the last beat is loaded. The output register holds a beat while
// out_stall is high; the sequencer waits on it. Reset clears the sequencer
// and output valid and restores the decimal table "0123456789".
`include "integer_to_radix_symbols_unit_defines.svh"

module integer_to_radix_symbols_unit import i2r_pkg::*; #(
	parameter int MAX_BASE   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [SYM_W-1:0]            symbol,
	output logic                        last,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [SYMS_W-1:0]           cfg_wdata
);

	localparam int DIGIT_W = $clog2(MAX_BASE);
	localparam int AW      = $clog2(VALUE_BITS);
	localparam int ND_W    = $clog2(VALUE_BITS + 1);

	// Configuration registers.
	logic [LEN_W-1:0]  base_len_q;
	logic [SYMS_W-1:0] syms_lo_q, syms_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_len_q <= BASE_LEN_RST;
			syms_lo_q  <= SYMS_LO_RST;
			syms_hi_q  <= SYMS_HI_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BASE_LEN: base_len_q <= cfg_wdata[LEN_W-1:0];
				CFG_SYMS_LO:  syms_lo_q  <= cfg_wdata;
				CFG_SYMS_HI:  syms_hi_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Table check: radix in range and no sign symbol among those in use.
	logic [2*SYMS_W-1:0] sym_table;
	logic                table_ok;

	assign sym_table = {syms_hi_q, syms_lo_q};

	always_comb begin : table_check
		logic             bad;
		logic [SYM_W-1:0] s;
		bad = 1'b0;
		s   = '0;
		for (int i = 0; i < NUM_SYMS; i++) begin
			s = sym_table[i*SYM_W +: SYM_W];
			if ((LEN_W'(i) < base_len_q) && (s == SYM_PLUS || s == SYM_MINUS)) begin
				bad = 1'b1;
			end
		end
		table_ok = !bad && (base_len_q >= LEN_W'(MIN_BASE))
			&& (base_len_q <= LEN_W'(MAX_BASE));
	end

	// Magnitude as an unsigned number, so the most negative value is exact.
	logic                  in_neg;
	logic [VALUE_BITS-1:0] in_mag;

	assign in_neg = value[VALUE_BITS-1];
	assign in_mag = in_neg ? (~value + VALUE_BITS'(1)) : value;

	// Sequencer state and strobes.
	i2r_state_t       state_q, state_d;
	div_ctrl_t        div_ctrl;
	div_stat_t        div_stat;
	logic [DIGIT_W-1:0] div_digit;
	logic             start, digit_wr, run_done;
	logic             ram_re, out_load, load_minus;
	logic             slot_free;
	logic             neg_q;
	logic [ND_W-1:0]  nd_q;
	logic [AW-1:0]    ptr_q, ram_raddr;
	logic [DIGIT_W-1:0] ram_rdata;
	logic             accept;

	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid || !out_stall;
	assign ram_raddr = (state_q == ST_READ) ? ptr_q : (ptr_q - AW'(1));

	always_comb begin
		state_d       = state_q;
		in_stall      = 1'b1;
		div_ctrl.load = 1'b0;
		div_ctrl.run  = 1'b0;
		start         = 1'b0;
		digit_wr      = 1'b0;
		run_done      = 1'b0;
		ram_re        = 1'b0;
		out_load      = 1'b0;
		load_minus    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				// Drop the value when the table is unusable.
				if (in_valid && table_ok) begin
					start         = 1'b1;
					div_ctrl.load = 1'b1;
					state_d       = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				div_ctrl.run = 1'b1;
				digit_wr     = div_stat.digit_valid;
				if (div_stat.digit_valid &&
				    (div_stat.quot_zero || nd_q == ND_W'(VALUE_BITS - 1))) begin
					run_done = 1'b1;
					state_d  = neg_q ? ST_SIGN : ST_READ;
				end
			end
			ST_SIGN: begin
				if (slot_free) begin
					out_load   = 1'b1;
					load_minus = 1'b1;
					state_d    = ST_READ;
				end
			end
			ST_READ: begin
				ram_re  = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					out_load = 1'b1;
					if (ptr_q == '0) begin
						state_d = ST_IDLE;
					end else begin
						ram_re = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Digit count and read pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_q  <= '0;
			ptr_q <= '0;
			neg_q <= 1'b0;
		end else begin
			if (start) begin
				nd_q  <= '0;
				neg_q <= in_neg;
			end else if (digit_wr) begin
				nd_q <= nd_q + ND_W'(1);
			end
			// Most significant digit is the one written last.
			if (run_done) begin
				ptr_q <= nd_q[AW-1:0];
			end else if (state_q == ST_EMIT && ram_re) begin
				ptr_q <= ptr_q - AW'(1);
			end
		end
	end

	i2r_divider #(
		.VALUE_BITS (VALUE_BITS),
		.DIGIT_W    (DIGIT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.load_mag (in_mag),
		.radix    (base_len_q[DIGIT_W:0]),
		.digit    (div_digit),
		.stat     (div_stat)
	);

	i2r_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (VALUE_BITS)
	) u_digits (
		.clk   (clk),
		.we    (digit_wr),
		.waddr (nd_q[AW-1:0]),
		.wdata (div_digit),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output beat register: hold while stalled, advance when taken.
	logic [SYM_IDX_W-1:0] sym_idx;
	logic [SYM_W-1:0]     digit_sym;

	assign sym_idx   = SYM_IDX_W'(ram_rdata);
	assign digit_sym = sym_table[{sym_idx, 3'b000} +: SYM_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			symbol <= load_minus ? SYM_MINUS : digit_sym;
			last   <= !load_minus && (ptr_q == '0);
		end
	end

	// Checks on the sequencer.
	`I2R_ASSERT_NEXT(a_busy_after_start, accept && table_ok, in_stall)
	`I2R_ASSERT_NEXT(a_idle_after_last, out_load && !load_minus && ptr_q == '0, state_q == ST_IDLE)
	`I2R_ASSERT_NEXT(a_sign_leads, out_load && load_minus, out_valid && !last)
	`I2R_ASSERT_ALWAYS(a_digit_bound, nd_q <= ND_W'(VALUE_BITS))

endmodule

// ===== hw/rtl/i2r_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2r_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/i2r_divider.sv =====
// Shared divide-by-radix unit: one chunk of the dividend per cycle while ctrl.run is high.
// Depends on i2r_pkg.
module i2r_divider import i2r_pkg::*; #(
	parameter int VALUE_BITS = 32,
	parameter int DIGIT_W    = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  div_ctrl_t             ctrl,
	input  logic [VALUE_BITS-1:0] load_mag,
	input  logic [DIGIT_W:0]      radix,
	output logic [DIGIT_W-1:0]    digit,
	output div_stat_t             stat
);

	localparam int NCHUNK = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
	localparam int PAD    = NCHUNK * CHUNK_BITS;
	localparam int CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

	logic [PAD-1:0]     dvd_q, dvd_next;
	logic [DIGIT_W-1:0] rem_q, rem_next;
	logic [CNT_W-1:0]   cnt_q;
	logic               last_chunk;

	// Restoring division of the top chunk, remainder carried bit by bit.
	always_comb begin : chunk_div
		logic [DIGIT_W:0]    t;
		logic [DIGIT_W-1:0]  r;
		logic [CHUNK_BITS-1:0] q;
		r = rem_q;
		q = '0;
		t = '0;
		for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
			t = {r, dvd_q[PAD-CHUNK_BITS+i]};
			if (t >= radix) begin
				q[i] = 1'b1;
				r    = DIGIT_W'(t - radix);
			end else begin
				r = t[DIGIT_W-1:0];
			end
		end
		rem_next = r;
		dvd_next = (dvd_q << CHUNK_BITS) | PAD'(q);
	end

	assign last_chunk       = (cnt_q == CNT_W'(NCHUNK - 1));
	assign digit            = rem_next;
	assign stat.digit_valid = ctrl.run && last_chunk;
	assign stat.quot_zero   = (dvd_next == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			cnt_q <= '0;
		end else if (ctrl.load) begin
			rem_q <= '0;
			cnt_q <= '0;
		end else if (ctrl.run) begin
			if (last_chunk) begin
				rem_q <= '0;
				cnt_q <= '0;
			end else begin
				rem_q <= rem_next;
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Dividend turns into the quotient as chunks shift through.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			dvd_q <= PAD'(load_mag);
		end else if (ctrl.run) begin
			dvd_q <= dvd_next;
		end
	end

endmodule
